>>> rtl/imq_pkg.sv
// Shared types and constants for the indexed message queue.
package imq_pkg;

  localparam int MAX_ENTRIES_DEF  = 16;
  localparam int HANDLE_WIDTH_DEF = 32;

  localparam int REQ_W = 4;
  localparam int MSG_W = 32;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;
  localparam int DL_W  = 5;

  localparam logic [DL_W-1:0] DEPTH_RESET = DL_W'(16);

  typedef enum logic [REQ_W-1:0] {
    REQ_POST       = 4'd0,
    REQ_TAKE_FIRST = 4'd1,
    REQ_TAKE_LAST  = 4'd2,
    REQ_TAKE_AT    = 4'd3,
    REQ_PEEK_FIRST = 4'd4,
    REQ_PEEK_LAST  = 4'd5,
    REQ_PEEK_AT    = 4'd6,
    REQ_FIND       = 4'd7,
    REQ_SWAP       = 4'd8,
    REQ_ROTATE     = 4'd9
  } req_t;

  typedef enum logic [1:0] {RD_PTR, RD_PTR1, RD_B, RD_ZERO} rd_sel_t;
  typedef enum logic [1:0] {WA_COUNT, WA_PTR, WA_B} wa_sel_t;
  typedef enum logic [1:0] {WD_MSG, WD_RDATA, WD_TMP} wd_sel_t;
  typedef enum logic [2:0] {PTR_HOLD, PTR_ZERO, PTR_LAST, PTR_A, PTR_INC} ptr_op_t;

  typedef struct packed {
    logic    in_ready;
    logic    load_req;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
    ptr_op_t ptr_op;
    logic    tmp_load;
    logic    msg_load;
    logic    set_ok;
    logic    set_found;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
  } imq_cmd_t;

  typedef struct packed {
    req_t req;
    logic in_valid;
    logic out_free;
    logic post_ok;
    logic nonempty;
    logic multi;
    logic a_ok;
    logic swap_ok;
    logic more;
    logic scan_more;
    logic match;
  } imq_stat_t;

endpackage

>>> rtl/imq_if.sv
// Request, result and configuration channel interfaces.
interface imq_req_if;
  import imq_pkg::*;
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [MSG_W-1:0] msg_in;
  logic [IDX_W-1:0] index_a;
  logic [IDX_W-1:0] index_b;
  modport source (output valid, req_type, msg_in, index_a, index_b, input ready);
  modport sink (input valid, req_type, msg_in, index_a, index_b, output ready);
endinterface

interface imq_res_if;
  import imq_pkg::*;
  logic             valid;
  logic             ready;
  logic             ok;
  logic [MSG_W-1:0] msg_out;
  logic [IDX_W-1:0] index_out;
  logic [CNT_W-1:0] count_out;
  logic             full_res;
  logic             empty_res;
  modport source (output valid, ok, msg_out, index_out, count_out, full_res, empty_res,
                  input ready);
  modport sink (input valid, ok, msg_out, index_out, count_out, full_res, empty_res,
                output ready);
endinterface

interface imq_cfg_if;
  import imq_pkg::*;
  logic            valid;
  logic            ready;
  logic [DL_W-1:0] depth_limit;
  modport source (output valid, depth_limit, input ready);
  modport sink (input valid, depth_limit, output ready);
endinterface

>>> rtl/imq_ctrl.sv
// Request sequencer for the indexed message queue.
module imq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  imq_pkg::imq_stat_t  stat,
  output imq_pkg::imq_cmd_t   cmd
);
  import imq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_POS_RD, S_POS_CAP, S_SH_RD, S_SH_WR, S_ROT_RD0, S_ROT_CAP,
    S_ROT_WR, S_HEAD_RD, S_HEAD_CAP, S_FIND_RD, S_FIND_CMP, S_SW_RDA, S_SW_RDB,
    S_SW_WRA, S_SW_WRB, S_FINISH
  } state_t;

  state_t state, state_next;
  logic   is_take;

  assign is_take = (stat.req == REQ_TAKE_FIRST) || (stat.req == REQ_TAKE_LAST) ||
                   (stat.req == REQ_TAKE_AT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_PTR;
    cmd.wa_sel = WA_PTR;
    cmd.wd_sel = WD_RDATA;
    cmd.ptr_op = PTR_HOLD;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_FINISH;
        unique case (stat.req)
          REQ_POST: begin
            if (stat.post_ok) begin
              cmd.wr_en   = 1'b1;
              cmd.wa_sel  = WA_COUNT;
              cmd.wd_sel  = WD_MSG;
              cmd.cnt_inc = 1'b1;
              cmd.set_ok  = 1'b1;
            end
          end
          REQ_TAKE_FIRST, REQ_PEEK_FIRST: begin
            if (stat.nonempty) begin
              cmd.ptr_op = PTR_ZERO;
              cmd.set_ok = 1'b1;
              state_next = S_POS_RD;
            end
          end
          REQ_TAKE_LAST, REQ_PEEK_LAST: begin
            if (stat.nonempty) begin
              cmd.ptr_op = PTR_LAST;
              cmd.set_ok = 1'b1;
              state_next = S_POS_RD;
            end
          end
          REQ_TAKE_AT, REQ_PEEK_AT: begin
            if (stat.a_ok) begin
              cmd.ptr_op = PTR_A;
              cmd.set_ok = 1'b1;
              state_next = S_POS_RD;
            end
          end
          REQ_FIND: begin
            cmd.ptr_op = PTR_ZERO;
            state_next = S_FIND_RD;
          end
          REQ_SWAP: begin
            if (stat.swap_ok) begin
              cmd.ptr_op = PTR_A;
              cmd.set_ok = 1'b1;
              state_next = S_SW_RDA;
            end
          end
          REQ_ROTATE: begin
            if (stat.nonempty) begin
              cmd.ptr_op = PTR_ZERO;
              cmd.set_ok = 1'b1;
              state_next = stat.multi ? S_ROT_RD0 : S_HEAD_RD;
            end
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_POS_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_POS_CAP;
      end
      S_POS_CAP: begin
        cmd.msg_load = 1'b1;
        state_next   = is_take ? S_SH_RD : S_FINISH;
      end
      S_SH_RD: begin
        if (stat.more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR1;
          state_next = S_SH_WR;
        end else if (stat.req == REQ_ROTATE) begin
          state_next = S_ROT_WR;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_FINISH;
        end
      end
      S_SH_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.ptr_op = PTR_INC;
        state_next = S_SH_RD;
      end
      S_ROT_RD0: begin
        cmd.rd_en  = 1'b1;
        state_next = S_ROT_CAP;
      end
      S_ROT_CAP: begin
        cmd.tmp_load = 1'b1;
        state_next   = S_SH_RD;
      end
      S_ROT_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wd_sel = WD_TMP;
        state_next = S_HEAD_RD;
      end
      S_HEAD_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_ZERO;
        state_next = S_HEAD_CAP;
      end
      S_HEAD_CAP: begin
        cmd.msg_load = 1'b1;
        state_next   = S_FINISH;
      end
      S_FIND_RD: begin
        if (stat.scan_more) begin
          cmd.rd_en  = 1'b1;
          state_next = S_FIND_CMP;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FIND_CMP: begin
        if (stat.match) begin
          cmd.set_found = 1'b1;
          state_next    = S_FINISH;
        end else begin
          cmd.ptr_op = PTR_INC;
          state_next = S_FIND_RD;
        end
      end
      S_SW_RDA: begin
        cmd.rd_en  = 1'b1;
        state_next = S_SW_RDB;
      end
      S_SW_RDB: begin
        cmd.tmp_load = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_B;
        state_next   = S_SW_WRA;
      end
      S_SW_WRA: begin
        cmd.wr_en  = 1'b1;
        state_next = S_SW_WRB;
      end
      S_SW_WRB: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_B;
        cmd.wd_sel = WD_TMP;
        state_next = S_HEAD_RD;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/imq_dp.sv
// Entry memory, fill count, scan pointer and result register.
module imq_dp #(
  parameter int MAX_ENTRIES  = imq_pkg::MAX_ENTRIES_DEF,
  parameter int HANDLE_WIDTH = imq_pkg::HANDLE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  imq_req_if.sink            req,
  imq_res_if.source          res,
  imq_cfg_if.sink            cfg,
  input  imq_pkg::imq_cmd_t  cmd,
  output imq_pkg::imq_stat_t stat
);
  import imq_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int XW = (CW > DL_W) ? CW : DL_W;

  logic [HANDLE_WIDTH-1:0] mem [MAX_ENTRIES];
  logic [HANDLE_WIDTH-1:0] rdata;
  logic [HANDLE_WIDTH-1:0] tmp;
  logic [HANDLE_WIDTH-1:0] msg_h;
  logic [HANDLE_WIDTH-1:0] res_msg;
  logic [HANDLE_WIDTH-1:0] wd;
  logic [IDX_W-1:0]        ia, ib, res_idx;
  logic                    res_ok;
  req_t                    req_q;
  logic [CW-1:0]           cnt, ptr;
  logic [DL_W-1:0]         depth_limit;
  logic                    out_valid;
  logic [AW-1:0]           ra, wa;
  logic [XW-1:0]           cnt_x, ptr_x, ia_x, ib_x, dl_x, max_x, eff_x;

  assign cnt_x = XW'(cnt);
  assign ptr_x = XW'(ptr);
  assign ia_x  = XW'(ia);
  assign ib_x  = XW'(ib);
  assign dl_x  = XW'(depth_limit);
  assign max_x = XW'(MAX_ENTRIES);
  assign eff_x = (dl_x > max_x) ? max_x : dl_x;

  assign req.ready = cmd.in_ready;
  assign cfg.ready = 1'b1;

  assign stat.req       = req_q;
  assign stat.in_valid  = req.valid;
  assign stat.out_free  = !out_valid || res.ready;
  assign stat.post_ok   = cnt_x < eff_x;
  assign stat.nonempty  = cnt != '0;
  assign stat.multi     = cnt_x >= XW'(2);
  assign stat.a_ok      = ia_x < cnt_x;
  assign stat.swap_ok   = (ia_x != ib_x) && (ia_x < cnt_x) && (ib_x < cnt_x);
  assign stat.more      = XW'(ptr_x + XW'(1)) < cnt_x;
  assign stat.scan_more = ptr_x < cnt_x;
  assign stat.match     = rdata == msg_h;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_PTR:  ra = ptr[AW-1:0];
      RD_PTR1: ra = AW'(ptr[AW-1:0] + 1'b1);
      RD_B:    ra = ib_x[AW-1:0];
      RD_ZERO: ra = '0;
      default: ra = '0;
    endcase
    unique case (cmd.wa_sel)
      WA_COUNT: wa = cnt[AW-1:0];
      WA_PTR:   wa = ptr[AW-1:0];
      WA_B:     wa = ib_x[AW-1:0];
      default:  wa = ptr[AW-1:0];
    endcase
    unique case (cmd.wd_sel)
      WD_MSG:   wd = msg_h;
      WD_RDATA: wd = rdata;
      WD_TMP:   wd = tmp;
      default:  wd = rdata;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wa] <= wd;
    end
    if (cmd.rd_en) begin
      rdata <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q   <= req_t'(req.req_type);
      msg_h   <= HANDLE_WIDTH'(req.msg_in);
      ia      <= req.index_a;
      ib      <= req.index_b;
      res_ok  <= 1'b0;
      res_msg <= '0;
      res_idx <= '0;
    end else begin
      if (cmd.set_ok) begin
        res_ok <= 1'b1;
      end
      if (cmd.set_found) begin
        res_ok  <= 1'b1;
        res_idx <= ptr_x[IDX_W-1:0];
      end
      if (cmd.msg_load) begin
        res_msg <= rdata;
      end
    end
    if (cmd.tmp_load) begin
      tmp <= rdata;
    end
    unique case (cmd.ptr_op)
      PTR_HOLD: ptr <= ptr;
      PTR_ZERO: ptr <= '0;
      PTR_LAST: ptr <= CW'(cnt - 1'b1);
      PTR_A:    ptr <= ia_x[CW-1:0];
      PTR_INC:  ptr <= CW'(ptr + 1'b1);
      default:  ptr <= ptr;
    endcase
    if (cmd.out_load) begin
      res.ok        <= res_ok;
      res.msg_out   <= MSG_W'(res_msg);
      res.index_out <= res_idx;
      res.count_out <= cnt_x[CNT_W-1:0];
      res.full_res  <= cnt_x >= eff_x;
      res.empty_res <= cnt == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      depth_limit <= DEPTH_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        cnt <= CW'(cnt + 1'b1);
      end else if (cmd.cnt_dec) begin
        cnt <= CW'(cnt - 1'b1);
      end
      if (cfg.valid) begin
        depth_limit <= cfg.depth_limit;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign res.valid = out_valid;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_x <= max_x) else $error("fill count above capacity");

  a_cnt_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.cnt_inc && !cmd.cnt_dec |=> $stable(cnt)) else $error("fill count moved");

  a_post_inc: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en && cmd.wa_sel == WA_COUNT |-> cmd.cnt_inc && stat.post_ok)
    else $error("tail write without count update");

  a_cap_after_rd: assert property (@(posedge clk) disable iff (rst)
    cmd.msg_load || cmd.tmp_load |-> $past(cmd.rd_en)) else $error("capture without read");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid || res.ready) else $error("result overwritten");

endmodule

>>> rtl/indexed_message_queue.sv
// Top level of the indexed message queue.
//   channel | dir | handshake          | payload
//   req     | in  | req.valid/ready    | req_type, msg_in, index_a, index_b
//   res     | out | res.valid/ready    | ok, msg_out, index_out, count_out, flags
//   cfg     | in  | cfg.valid/ready    | depth_limit (always ready)
// One request at a time through a single-port entry memory with registered read.
// Post and failed requests go from decode straight to the result; peek reads the
// entry; take reads it and moves each later entry down one place; find compares
// entries from the head until a hit or the end; rotate moves the head to the tail
// (for more than one entry), swap exchanges two entries, and both read the head.
// Synchronous reset empties the queue and sets depth_limit to 16.
// A new request is taken while the previous result still waits on res.
module indexed_message_queue #(
  parameter int MAX_ENTRIES  = imq_pkg::MAX_ENTRIES_DEF,
  parameter int HANDLE_WIDTH = imq_pkg::HANDLE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  imq_req_if.sink   req,
  imq_res_if.source res,
  imq_cfg_if.sink   cfg
);
  import imq_pkg::*;

  imq_cmd_t  cmd;
  imq_stat_t stat;

  imq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  imq_dp #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .res  (res),
    .cfg  (cfg),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule
